// File: hdl/pdcm_pkg.sv
package pdcm_pkg;

    localparam int DUTY_W = 16;
    localparam int DUTY_STEPS = DUTY_W;
    localparam int STEP_CNT_W = $clog2(DUTY_STEPS);

    localparam logic [DUTY_W-1:0] FULL_SCALE_RESET = 16'd1000;

    localparam logic ACTION_EDGE = 1'b0;
    localparam logic ACTION_READ = 1'b1;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_MUL,
        BK_CHK,
        BK_DIV,
        BK_DONE
    } pdcm_back_state_t;

    typedef struct packed {
        logic              zero_interval;
        logic [DUTY_W-1:0] duty_value;
    } pdcm_result_t;

    typedef struct packed {
        logic full;
        logic empty;
    } pdcm_q_status_t;

endpackage

// File: hdl/pulse_duty_cycle_meter_top.sv
// Duty-cycle meter for one sensor line.
// Slave channel s_*: one request per line edge (s_tuser = 0) or duty read
// (s_tuser = 1), carrying the line level and a free-running tick stamp.
// Master channel m_*: one request per read, duty value in m_tdata and the
// zero-interval flag in m_tuser; edges produce nothing.
// A read is classified, queued (two entries), then worked by a shift-add
// multiply, a range check and a restoring divide; the serial
// multiply/divide unit works one read at a time and takes the next from
// the queue only after the last result has gone to the output register.
// A read with zero elapsed ticks skips the arithmetic.
// Reset (aresetn low, synchronous) clears the line state, accumulator and
// read reference, and sets full_scale to 1000.
// If the receiver stalls, the finished result holds in the output register,
// the divider waits with the next result, and the queue keeps taking reads
// until full; edge requests are then held off too.
// Write full_scale through cfg_wr_en/cfg_wr_data only while idle.
module pulse_duty_cycle_meter_top #(
    parameter int STAMP_BITS = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [0] line_level, [32:1] timestamp, [39:33] zero fill
    input  logic [39:0] s_tdata,
    // [0] action
    input  logic        s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [15:0] duty_value
    output logic [15:0] m_tdata,
    // [0] zero_interval
    output logic        m_tuser,
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data
);
    import pdcm_pkg::*;

    localparam int JOB_W = 2 * STAMP_BITS;

    logic [DUTY_W-1:0] full_scale_reg, full_scale_next;

    pdcm_q_status_t q_status;
    logic           q_push;
    logic           q_pop;
    logic [JOB_W-1:0] q_push_data;
    logic [JOB_W-1:0] q_pop_data;
    pdcm_result_t   result;

    // Hold the scale register; take a write whenever enabled.
    assign full_scale_next = cfg_wr_en ? cfg_wr_data : full_scale_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            full_scale_reg <= FULL_SCALE_RESET;
        end else begin
            full_scale_reg <= full_scale_next;
        end
    end

    // Classify requests and advance the line state.
    pdcm_front #(
        .STAMP_BITS(STAMP_BITS)
    ) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .in_action(s_tuser),
        .in_level (s_tdata[0]),
        .in_stamp (s_tdata[32:1]),
        .q_status (q_status),
        .q_push   (q_push),
        .q_data   (q_push_data)
    );

    // Buffer read jobs between classifier and arithmetic.
    pdcm_queue #(
        .WIDTH(JOB_W)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_data(q_push_data),
        .pop      (q_pop),
        .pop_data (q_pop_data),
        .status   (q_status)
    );

    // Scale, divide and saturate each read.
    pdcm_back #(
        .STAMP_BITS(STAMP_BITS)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .full_scale(full_scale_reg),
        .q_status  (q_status),
        .q_data    (q_pop_data),
        .q_pop     (q_pop),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_result(result)
    );

    assign m_tdata = result.duty_value;
    assign m_tuser = result.zero_interval;

endmodule

// File: hdl/pdcm_front.sv
module pdcm_front #(
    parameter int STAMP_BITS = 32
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic                    in_action,
    input  logic                    in_level,
    input  logic [31:0]             in_stamp,
    input  pdcm_pkg::pdcm_q_status_t q_status,
    output logic                    q_push,
    output logic [2*STAMP_BITS-1:0] q_data
);
    import pdcm_pkg::*;

    logic                  line_high_reg, line_high_next;
    logic [STAMP_BITS-1:0] rise_reg, rise_next;
    logic [STAMP_BITS-1:0] high_reg, high_next;
    logic [STAMP_BITS-1:0] read_reg, read_next;

    logic                  take;
    logic [STAMP_BITS-1:0] now;
    logic [STAMP_BITS-1:0] high_closed;
    logic [STAMP_BITS-1:0] elapsed;

    // Hold off every request, edge or read, while the queue is full.
    assign in_ready = !q_status.full;
    assign take     = in_valid && in_ready;

    assign now         = STAMP_BITS'(in_stamp);
    assign high_closed = high_reg + (now - rise_reg);
    assign elapsed     = now - read_reg;

    always_comb begin
        line_high_next = line_high_reg;
        rise_next      = rise_reg;
        high_next      = high_reg;
        read_next      = read_reg;
        q_push         = 1'b0;
        q_data         = {line_high_reg ? high_closed : high_reg, elapsed};
        if (take) begin
            if (in_action == ACTION_EDGE) begin
                line_high_next = in_level;
                if (in_level) begin
                    rise_next = now;
                end else begin
                    high_next = high_closed;
                end
            end else begin
                q_push    = 1'b1;
                high_next = '0;
                read_next = now;
                if (line_high_reg) begin
                    rise_next = now;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            line_high_reg <= 1'b0;
            rise_reg      <= '0;
            high_reg      <= '0;
            read_reg      <= '0;
        end else begin
            line_high_reg <= line_high_next;
            rise_reg      <= rise_next;
            high_reg      <= high_next;
            read_reg      <= read_next;
        end
    end

endmodule

// File: hdl/pdcm_queue.sv
module pdcm_queue #(
    parameter int WIDTH = 64
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     push,
    input  logic [WIDTH-1:0]         push_data,
    input  logic                     pop,
    output logic [WIDTH-1:0]         pop_data,
    output pdcm_pkg::pdcm_q_status_t status
);
    import pdcm_pkg::*;

    logic [WIDTH-1:0] slot_reg [2];
    logic             wr_ptr_reg, wr_ptr_next;
    logic             rd_ptr_reg, rd_ptr_next;
    logic [1:0]       count_reg, count_next;

    assign status.full  = (count_reg == 2'd2);
    assign status.empty = (count_reg == 2'd0);
    assign pop_data     = slot_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// File: hdl/pdcm_back.sv
module pdcm_back #(
    parameter int STAMP_BITS = 32
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic [pdcm_pkg::DUTY_W-1:0]   full_scale,
    input  pdcm_pkg::pdcm_q_status_t      q_status,
    input  logic [2*STAMP_BITS-1:0]       q_data,
    output logic                          q_pop,
    output logic                          out_valid,
    input  logic                          out_ready,
    output pdcm_pkg::pdcm_result_t        out_result
);
    import pdcm_pkg::*;

    localparam int PROD_W = STAMP_BITS + DUTY_W;

    pdcm_back_state_t      state_reg, state_next;
    logic [STEP_CNT_W-1:0] cnt_reg, cnt_next;
    logic [STAMP_BITS-1:0] mcand_reg, mcand_next;
    logic [STAMP_BITS-1:0] elapsed_reg, elapsed_next;
    logic [DUTY_W-1:0]     fs_sh_reg, fs_sh_next;
    logic [PROD_W-1:0]     acc_reg, acc_next;
    logic                  zero_reg, zero_next;
    logic                  out_valid_reg, out_valid_next;
    pdcm_result_t          out_reg, out_next;

    logic [STAMP_BITS:0]   trial;
    logic                  trial_ge;
    logic [DUTY_W-1:0]     quot;

    assign out_valid  = out_valid_reg;
    assign out_result = out_reg;

    // One restoring step: remainder sits in the high part of acc, dividend
    // bits shift out of the low part while quotient bits shift in.
    assign trial    = {acc_reg[PROD_W-1:DUTY_W], acc_reg[DUTY_W-1]};
    assign trial_ge = (trial >= {1'b0, elapsed_reg});
    assign quot     = acc_reg[DUTY_W-1:0];

    always_comb begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        mcand_next     = mcand_reg;
        elapsed_next   = elapsed_reg;
        fs_sh_next     = fs_sh_reg;
        acc_next       = acc_reg;
        zero_next      = zero_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_next       = out_reg;
        q_pop          = 1'b0;
        case (state_reg)
            BK_IDLE: begin
                if (!q_status.empty) begin
                    q_pop        = 1'b1;
                    mcand_next   = q_data[2*STAMP_BITS-1:STAMP_BITS];
                    elapsed_next = q_data[STAMP_BITS-1:0];
                    fs_sh_next   = full_scale;
                    acc_next     = '0;
                    cnt_next     = STEP_CNT_W'(DUTY_STEPS - 1);
                    zero_next    = (q_data[STAMP_BITS-1:0] == '0);
                    if (q_data[STAMP_BITS-1:0] == '0) begin
                        acc_next   = PROD_W'(full_scale);
                        state_next = BK_DONE;
                    end else begin
                        state_next = BK_MUL;
                    end
                end
            end
            BK_MUL: begin
                acc_next   = {acc_reg[PROD_W-2:0], 1'b0}
                           + (fs_sh_reg[DUTY_W-1] ? PROD_W'(mcand_reg) : '0);
                fs_sh_next = {fs_sh_reg[DUTY_W-2:0], 1'b0};
                cnt_next   = cnt_reg - 1'b1;
                if (cnt_reg == '0) begin
                    state_next = BK_CHK;
                end
            end
            BK_CHK: begin
                // Quotient of 2^16 or more always exceeds full scale.
                cnt_next = STEP_CNT_W'(DUTY_STEPS - 1);
                if (acc_reg[PROD_W-1:DUTY_W] >= elapsed_reg) begin
                    acc_next   = PROD_W'(full_scale);
                    state_next = BK_DONE;
                end else begin
                    state_next = BK_DIV;
                end
            end
            BK_DIV: begin
                acc_next[PROD_W-1:DUTY_W] = trial_ge ?
                    STAMP_BITS'(trial - {1'b0, elapsed_reg}) : trial[STAMP_BITS-1:0];
                acc_next[DUTY_W-1:0] = {acc_reg[DUTY_W-2:0], trial_ge};
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0) begin
                    state_next = BK_DONE;
                end
            end
            BK_DONE: begin
                if (!out_valid_reg || out_ready) begin
                    out_valid_next         = 1'b1;
                    out_next.zero_interval = zero_reg;
                    out_next.duty_value    = (quot > full_scale) ? full_scale : quot;
                    state_next             = BK_IDLE;
                end
            end
            default: begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        mcand_reg   <= mcand_next;
        elapsed_reg <= elapsed_next;
        fs_sh_reg   <= fs_sh_next;
        acc_reg     <= acc_next;
        zero_reg    <= zero_next;
        cnt_reg     <= cnt_next;
        out_reg     <= out_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= BK_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule
